### rtl/pwfd_pkg.sv
`default_nettype none
package pwfd_pkg;

  localparam int FRAME_BITS_DEF  = 40;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int WIN_W    = 16;
  localparam int PRE_W    = 2;
  localparam int CFG_AW   = 3;
  localparam int IDX_W    = 6;
  localparam int BYTES_W  = 40;

  // Register indexes on the configuration port
  localparam logic [CFG_AW-1:0] REG_ZERO_MIN = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ZERO_MAX = 3'd1;
  localparam logic [CFG_AW-1:0] REG_ONE_MIN  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ONE_MAX  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_PREAMBLE = 3'd4;

  localparam logic [WIN_W-1:0] ZERO_MIN_RST = 16'd67;
  localparam logic [WIN_W-1:0] ZERO_MAX_RST = 16'd87;
  localparam logic [WIN_W-1:0] ONE_MIN_RST  = 16'd116;
  localparam logic [WIN_W-1:0] ONE_MAX_RST  = 16'd134;
  localparam logic [PRE_W-1:0] PREAMBLE_RST = 2'd2;

  typedef struct packed {
    logic [15:0] pulse_width;
    logic        frame_start;
  } pwfd_in_t;

  typedef struct packed {
    logic [7:0] humidity_whole;
    logic [7:0] humidity_fraction;
    logic [7:0] temperature_whole;
    logic [7:0] temperature_fraction;
    logic [7:0] checksum_byte;
    logic       checksum_ok;
    logic       bad_pulse;
  } pwfd_out_t;

endpackage
`default_nettype wire

### rtl/pulse_width_sensor_frame_decoder_top.sv
`default_nettype none
// A frame result is registered into the output buffer on the transfer of its last data pulse.
// Throughput: one pulse per cycle while in_stall is low; the frame logic is a single registered pass.
// A two-entry output buffer keeps pulses flowing while a result waits; in_stall
// rises only when both entries are held.
// Reset (synchronous, rst_n low): frame state and buffers clear, window and
// preamble registers return to 67, 87, 116, 134 and 2.
module pulse_width_sensor_frame_decoder_top #(
  parameter int FRAME_BITS  = pwfd_pkg::FRAME_BITS_DEF,
  parameter int COUNT_WIDTH = pwfd_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire pwfd_pkg::pwfd_in_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output pwfd_pkg::pwfd_out_t              out_data,
  input  wire logic                        cfg_we,
  input  wire logic [pwfd_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [pwfd_pkg::WIN_W-1:0]  cfg_wdata
);
  import pwfd_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH < WIN_W) ? COUNT_WIDTH : WIN_W;

  logic [CMP_W-1:0] zero_min_r, zero_max_r, one_min_r, one_max_r;
  logic [PRE_W-1:0] preamble_r;
  logic             in_fire, res_valid, buf_full;
  pwfd_out_t        res_data;

  assign in_stall = buf_full;
  assign in_fire  = in_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_min_r <= ZERO_MIN_RST[CMP_W-1:0];
      zero_max_r <= ZERO_MAX_RST[CMP_W-1:0];
      one_min_r  <= ONE_MIN_RST[CMP_W-1:0];
      one_max_r  <= ONE_MAX_RST[CMP_W-1:0];
      preamble_r <= PREAMBLE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ZERO_MIN: zero_min_r <= cfg_wdata[CMP_W-1:0];
        REG_ZERO_MAX: zero_max_r <= cfg_wdata[CMP_W-1:0];
        REG_ONE_MIN:  one_min_r  <= cfg_wdata[CMP_W-1:0];
        REG_ONE_MAX:  one_max_r  <= cfg_wdata[CMP_W-1:0];
        REG_PREAMBLE: preamble_r <= cfg_wdata[PRE_W-1:0];
        default: ;
      endcase
    end
  end

  pwfd_frame #(
    .FRAME_BITS (FRAME_BITS),
    .CMP_W      (CMP_W)
  ) u_frame (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_data        (in_data),
    .zero_min       (zero_min_r),
    .zero_max       (zero_max_r),
    .one_min        (one_min_r),
    .one_max        (one_max_r),
    .preamble_count (preamble_r),
    .res_valid      (res_valid),
    .res_data       (res_data)
  );

  pwfd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### rtl/pwfd_frame.sv
`default_nettype none
module pwfd_frame #(
  parameter int FRAME_BITS = 40,
  parameter int CMP_W      = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_fire,
  input  wire pwfd_pkg::pwfd_in_t     in_data,
  input  wire logic [CMP_W-1:0]       zero_min,
  input  wire logic [CMP_W-1:0]       zero_max,
  input  wire logic [CMP_W-1:0]       one_min,
  input  wire logic [CMP_W-1:0]       one_max,
  input  wire logic [pwfd_pkg::PRE_W-1:0] preamble_count,
  output logic                        res_valid,
  output pwfd_pkg::pwfd_out_t         res_data
);
  import pwfd_pkg::*;

  localparam int DCW = $clog2(FRAME_BITS + 1);

  logic [IDX_W-1:0]      idx_r, idx_nxt, idx_e;
  logic [FRAME_BITS-1:0] sh_r, sh_nxt, sh_e;
  logic                  bad_r, bad_nxt, bad_e;
  logic [DCW-1:0]        dcnt_r, dcnt_nxt, dcnt_e;
  logic [CMP_W-1:0]      w;
  logic                  is_one, is_zero, done_e, pre_e;
  logic [BYTES_W-1:0]    tail;
  logic [7:0]            sum;

  assign w       = in_data.pulse_width[CMP_W-1:0];
  assign is_one  = (w >= one_min) && (w <= one_max);
  assign is_zero = (w >= zero_min) && (w <= zero_max);

  always_comb begin
    // frame start clears the frame before the pulse is handled
    idx_e  = in_data.frame_start ? '0 : idx_r;
    sh_e   = in_data.frame_start ? '0 : sh_r;
    bad_e  = in_data.frame_start ? 1'b0 : bad_r;
    dcnt_e = in_data.frame_start ? '0 : dcnt_r;
    done_e = (dcnt_e == DCW'(FRAME_BITS));
    pre_e  = (dcnt_e == '0) && (idx_e < IDX_W'(preamble_count));

    idx_nxt   = idx_e;
    sh_nxt    = sh_e;
    bad_nxt   = bad_e;
    dcnt_nxt  = dcnt_e;
    res_valid = 1'b0;
    if (!done_e) begin
      if (pre_e) begin
        idx_nxt = idx_e + 1'b1;
      end else begin
        if (idx_e != '1) begin
          idx_nxt = idx_e + 1'b1;
        end
        sh_nxt   = {sh_e[FRAME_BITS-2:0], is_one};
        bad_nxt  = bad_e | ~(is_one | is_zero);
        dcnt_nxt = dcnt_e + 1'b1;
        res_valid = in_fire && (dcnt_nxt == DCW'(FRAME_BITS));
      end
    end
  end

  assign tail = BYTES_W'(sh_nxt);
  assign sum  = tail[39:32] + tail[31:24] + tail[23:16] + tail[15:8];

  always_comb begin
    res_data.humidity_whole       = tail[39:32];
    res_data.humidity_fraction    = tail[31:24];
    res_data.temperature_whole    = tail[23:16];
    res_data.temperature_fraction = tail[15:8];
    res_data.checksum_byte        = tail[7:0];
    res_data.checksum_ok          = (sum == tail[7:0]);
    res_data.bad_pulse            = bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      sh_r   <= '0;
      bad_r  <= 1'b0;
      dcnt_r <= '0;
    end else if (in_fire) begin
      idx_r  <= idx_nxt;
      sh_r   <= sh_nxt;
      bad_r  <= bad_nxt;
      dcnt_r <= dcnt_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/pwfd_skid.sv
`default_nettype none
module pwfd_skid (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire pwfd_pkg::pwfd_out_t push_data,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pwfd_pkg::pwfd_out_t      out_data
);
  import pwfd_pkg::*;

  logic      out_valid_r, skid_valid_r;
  pwfd_out_t out_data_r, skid_data_r;
  logic      pop;

  assign pop       = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign full      = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      // output stage free: drain the skid entry first
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule
`default_nettype wire

### tb/pulse_width_sensor_frame_decoder_top_tb.sv
`timescale 1ns / 100ps

module pulse_width_sensor_frame_decoder_top_tb;
  import pwfd_pkg::*;

  localparam int FRAME_BITS    = FRAME_BITS_DEF;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PULSES = 900;
  localparam int QUIET_AFTER   = 750;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic [2:0] {
    SHAPE_MID,      // widths anywhere inside the window of the bit
    SHAPE_EDGE,     // widths on the window limits
    SHAPE_STRAY,    // zero bits sent outside both windows
    SHAPE_NOISY,    // now and then a width from the whole range
    SHAPE_TAIL,     // extra pulses after the frame has completed
    SHAPE_RESTART,  // aborted frame first, then a fresh one
    SHAPE_REPRE     // preamble length rewritten after a few data bits
  } pulse_shape_e;

  typedef struct packed {
    logic [15:0]  zero_lo;
    logic [15:0]  zero_hi;
    logic [15:0]  one_lo;
    logic [15:0]  one_hi;
    logic [1:0]   lead;
    pulse_shape_e shape;
    logic [39:0]  bits;
    logic         typed;
    pwfd_out_t    frame;
  } frame_case_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  pwfd_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  pwfd_out_t             out_data;
  logic                  cfg_we;
  logic [CFG_AW-1:0]     cfg_addr;
  logic [WIN_W-1:0]      cfg_wdata;

  // decoder state as the block should hold it
  logic [15:0]           win_zero_lo, win_zero_hi, win_one_lo, win_one_hi;
  logic [1:0]            preamble_len;
  logic [IDX_W-1:0]      frame_pulses;
  logic [FRAME_BITS-1:0] frame_bits;
  logic                  frame_bad;
  int                    bits_taken;

  pwfd_out_t             pending_frames[$];
  pwfd_out_t             oldest_frame;
  pwfd_out_t             typed_frame;
  bit                    use_typed = 1'b0;
  bit                    quiet = 1'b0;
  int                    idle_odds = 0;
  int                    pulses_sent = 0;
  int                    mismatch_count = 0;
  int                    cycle_count = 0;
  frame_case_t           frame_cases [10];

  pulse_width_sensor_frame_decoder_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL pulse_width_sensor_frame_decoder_top");
      $finish;
    end
  end

  function automatic void drop_frame();
    frame_pulses = '0;
    frame_bits   = '0;
    frame_bad    = 1'b0;
    bits_taken   = 0;
  endfunction

  // Advance the decoder state by one pulse; returns 1 when a frame completes.
  function automatic bit decode_pulse(input pwfd_in_t p, output pwfd_out_t frame);
    logic       hit_one, hit_zero;
    logic [7:0] byte_sum;
    frame = '0;
    if (p.frame_start) drop_frame();
    if (bits_taken >= FRAME_BITS) return 1'b0;
    if (bits_taken == 0 && frame_pulses < preamble_len) begin
      frame_pulses++;
      return 1'b0;
    end
    if (frame_pulses != '1) frame_pulses++;
    hit_one  = p.pulse_width >= win_one_lo && p.pulse_width <= win_one_hi;
    hit_zero = p.pulse_width >= win_zero_lo && p.pulse_width <= win_zero_hi;
    if (!hit_one && !hit_zero) frame_bad = 1'b1;
    frame_bits = {frame_bits[FRAME_BITS-2:0], hit_one};
    bits_taken++;
    if (bits_taken < FRAME_BITS) return 1'b0;
    frame.humidity_whole       = frame_bits[39:32];
    frame.humidity_fraction    = frame_bits[31:24];
    frame.temperature_whole    = frame_bits[23:16];
    frame.temperature_fraction = frame_bits[15:8];
    frame.checksum_byte        = frame_bits[7:0];
    byte_sum = frame_bits[39:32] + frame_bits[31:24] + frame_bits[23:16] + frame_bits[15:8];
    frame.checksum_ok          = byte_sum == frame_bits[7:0];
    frame.bad_pulse            = frame_bad;
    return 1'b1;
  endfunction

  function automatic logic [15:0] width_for(input logic b, input pulse_shape_e shape,
                                            input int n);
    logic [15:0] lo, hi;
    int          floor_w, ceil_w;
    lo = b ? win_one_lo : win_zero_lo;
    hi = b ? win_one_hi : win_zero_hi;
    if (shape == SHAPE_STRAY && !b) begin
      floor_w = (win_zero_lo < win_one_lo) ? win_zero_lo : win_one_lo;
      ceil_w  = (win_zero_hi > win_one_hi) ? win_zero_hi : win_one_hi;
      if (floor_w != 0 && (ceil_w == 65535 || $urandom_range(0, 1) == 1))
        return 16'($urandom_range(floor_w - 1, 0));
      if (ceil_w != 65535) return 16'($urandom_range(65535, ceil_w + 1));
      return 16'($urandom);
    end
    if (shape == SHAPE_NOISY && $urandom_range(0, 11) == 0) return 16'($urandom);
    if (shape == SHAPE_EDGE) return n[0] ? hi : lo;
    if (lo > hi) return 16'($urandom);
    return 16'($urandom_range(hi, lo));
  endfunction

  task automatic send_pulse(input logic [15:0] width, input logic start);
    pwfd_in_t  item;
    pwfd_out_t frame;
    bit        accepted;
    bit        live;
    item.pulse_width = width;
    item.frame_start = start;
    if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    accepted = 1'b0;
    // in_stall is settled by the falling edge, so sample it there
    while (!accepted) begin
      @(negedge clk);
      accepted = !in_stall;
      @(posedge clk);
    end
    live = start || bits_taken < FRAME_BITS;
    if (decode_pulse(item, frame)) pending_frames.push_back(use_typed ? typed_frame : frame);
    if (live) pulses_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_AW-1:0] addr, input logic [WIN_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    case (addr)
      REG_ZERO_MIN: win_zero_lo = value;
      REG_ZERO_MAX: win_zero_hi = value;
      REG_ONE_MIN:  win_one_lo = value;
      REG_ONE_MAX:  win_one_hi = value;
      REG_PREAMBLE: preamble_len = value[PRE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [15:0] zlo, input logic [15:0] zhi,
                              input logic [15:0] olo, input logic [15:0] ohi,
                              input logic [1:0] lead);
    settle();
    put_reg(REG_ZERO_MIN, zlo);
    put_reg(REG_ZERO_MAX, zhi);
    put_reg(REG_ONE_MIN, olo);
    put_reg(REG_ONE_MAX, ohi);
    // upper bits of the preamble write are don't-care
    put_reg(REG_PREAMBLE, {14'($urandom), lead});
    cfg_we <= 1'b0;
  endtask

  task automatic shuffle_windows();
    logic [15:0] zlo, zhi, olo, ohi;
    int          pick;
    pick = $urandom_range(0, 3);
    case (pick)
      0: begin
        zlo = ZERO_MIN_RST; zhi = ZERO_MAX_RST; olo = ONE_MIN_RST; ohi = ONE_MAX_RST;
      end
      1: begin
        zlo = 16'($urandom_range(20000, 0));
        zhi = zlo + 16'($urandom_range(2000, 0));
        olo = zhi + 16'($urandom_range(3000, 1));
        ohi = olo + 16'($urandom_range(2000, 0));
      end
      2: begin
        zlo = 16'd0;
        zhi = 16'($urandom_range(30000, 0));
        olo = 16'($urandom_range(65535, 30001));
        ohi = 16'hFFFF;
      end
      default: begin
        zlo = 16'($urandom); zhi = 16'($urandom); olo = 16'($urandom); ohi = 16'($urandom);
      end
    endcase
    program_regs(zlo, zhi, olo, ohi, 2'($urandom));
  endtask

  task automatic run_frame(input logic [39:0] bits, input pulse_shape_e shape, input int count);
    int n;
    bit first;
    first = 1'b1;
    for (n = 0; n < preamble_len; n++) begin
      send_pulse(16'($urandom), first);
      first = 1'b0;
    end
    for (n = 0; n < count; n++) begin
      if (shape == SHAPE_REPRE && n == 5)
        program_regs(win_zero_lo, win_zero_hi, win_one_lo, win_one_hi, 2'(preamble_len + 2'd1));
      send_pulse(width_for(bits[FRAME_BITS-1-n], shape, n), first);
      first = 1'b0;
    end
    if (shape == SHAPE_TAIL) repeat (4) send_pulse(16'($urandom), 1'b0);
  endtask

  // Check each result transfer; it completes at the next rising edge.
  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected frame result %h", $time, out_data);
      end else begin
        oldest_frame = pending_frames.pop_front();
        if (out_data !== oldest_frame) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: frame mismatch: bytes %h ok %b bad %b, wanted bytes %h ok %b bad %b",
                     $time, out_data[41:2], out_data.checksum_ok, out_data.bad_pulse,
                     oldest_frame[41:2], oldest_frame.checksum_ok, oldest_frame.bad_pulse);
        end
      end
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && !quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int           kind, pick, base_pulses;
    logic [39:0]  payload;
    pulse_shape_e shape;

    // window limits, lead, shape, bits, typed?, bytes + checksum ok + bad pulse
    frame_cases[0] = '{ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST, 2'd2, SHAPE_MID,
                       40'h00_0000_0000, 1'b1, {40'h00_0000_0000, 1'b1, 1'b0}};
    frame_cases[1] = '{ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST, 2'd2, SHAPE_EDGE,
                       40'hFF_FFFF_FFFF, 1'b1, {40'hFF_FFFF_FFFF, 1'b0, 1'b0}};
    frame_cases[2] = '{ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST, 2'd2, SHAPE_EDGE,
                       40'h01_0203_040A, 1'b1, {40'h01_0203_040A, 1'b1, 1'b0}};
    frame_cases[3] = '{ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST, 2'd2, SHAPE_STRAY,
                       40'hFF_00FF_00FE, 1'b1, {40'hFF_00FF_00FE, 1'b1, 1'b1}};
    frame_cases[4] = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 2'd0, SHAPE_EDGE,
                       40'hA5_5AC3_3CFE, 1'b1, {40'hA5_5AC3_3CFE, 1'b1, 1'b0}};
    // overlapping windows: a width in both is a one bit
    frame_cases[5] = '{16'd0, 16'hFFFF, 16'd100, 16'd200, 2'd3, SHAPE_MID,
                       40'h3C_960F_F05A, 1'b0, '0};
    frame_cases[6] = '{ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST, 2'd1, SHAPE_TAIL,
                       40'h12_3456_7814, 1'b1, {40'h12_3456_7814, 1'b1, 1'b0}};
    frame_cases[7] = '{ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST, 2'd2, SHAPE_RESTART,
                       40'hDE_ADBE_EF38, 1'b1, {40'hDE_ADBE_EF38, 1'b1, 1'b0}};
    frame_cases[8] = '{ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST, 2'd3, SHAPE_REPRE,
                       40'h80_4020_10F0, 1'b1, {40'h80_4020_10F0, 1'b1, 1'b0}};
    // empty zero window, one window over the whole range: every pulse is a one
    frame_cases[9] = '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 2'd1, SHAPE_MID,
                       40'h00_0000_0000, 1'b1, {40'hFF_FFFF_FFFF, 1'b0, 1'b0}};

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_ZERO_MIN;
    cfg_wdata <= '0;
    win_zero_lo  = ZERO_MIN_RST;
    win_zero_hi  = ZERO_MAX_RST;
    win_one_lo   = ONE_MIN_RST;
    win_one_hi   = ONE_MAX_RST;
    preamble_len = PREAMBLE_RST;
    drop_frame();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (frame_cases[i]) begin
      program_regs(frame_cases[i].zero_lo, frame_cases[i].zero_hi, frame_cases[i].one_lo,
                   frame_cases[i].one_hi, frame_cases[i].lead);
      idle_odds = (i % 3 == 0) ? 0 : 4;
      if (frame_cases[i].shape == SHAPE_RESTART) run_frame(~frame_cases[i].bits, SHAPE_MID, 17);
      use_typed   = frame_cases[i].typed;
      typed_frame = frame_cases[i].frame;
      run_frame(frame_cases[i].bits, frame_cases[i].shape, FRAME_BITS);
      use_typed = 1'b0;
    end

    base_pulses = pulses_sent;
    while ((pulses_sent - base_pulses) < RANDOM_PULSES) begin
      quiet     = (pulses_sent - base_pulses) >= QUIET_AFTER;
      idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(8, 3);
      if ($urandom_range(0, 5) == 0) shuffle_windows();
      payload = {32'($urandom), 8'($urandom)};
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        // right checksum about half the time
        if ($urandom_range(0, 1) == 1)
          payload[7:0] = payload[39:32] + payload[31:24] + payload[23:16] + payload[15:8];
        pick = $urandom_range(0, 7);
        shape = (pick < 5) ? SHAPE_MID : (pick == 5) ? SHAPE_EDGE :
                (pick == 6) ? SHAPE_STRAY : SHAPE_NOISY;
        run_frame(payload, shape, FRAME_BITS);
        if (kind < 3) repeat ($urandom_range(1, 3)) send_pulse(16'($urandom), 1'b0);
      end else if (kind < 17) begin
        run_frame(payload, SHAPE_MID, $urandom_range(FRAME_BITS - 1, 1));
      end else begin
        repeat ($urandom_range(1, 8)) send_pulse(16'($urandom), $urandom_range(0, 7) == 0);
      end
    end

    settle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_frames.size() == 0) begin
      $display("PASS pulse_width_sensor_frame_decoder_top");
    end else begin
      $display("FAIL pulse_width_sensor_frame_decoder_top");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pwfd_pkg.sv
rtl/pwfd_frame.sv
rtl/pwfd_skid.sv
rtl/pulse_width_sensor_frame_decoder_top.sv
tb/pulse_width_sensor_frame_decoder_top_tb.sv
